FILE: design/lsps_pkg.sv
// Shared types, constants and the per-stage divide/square-root step for the
// linear speed profile block. No dependencies.
package lsps_pkg;

    localparam int VAL_W   = 16;                 // every data field of the ports
    localparam int SQ_W    = 2 * VAL_W;          // speed squared, quotient
    localparam int RAD_W   = SQ_W + 2;           // sum of squares, padded to even
    localparam int ROOT_W  = RAD_W / 2;          // distance
    localparam int SREM_W  = ROOT_W + 3;         // square-root partial remainder
    localparam int DREM_W  = VAL_W + 1;          // divider partial remainder
    localparam int N_ITER  = SQ_W;               // one quotient bit per stage
    localparam int N_SQRT  = ROOT_W;             // one root bit per stage
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ACCEL_STEP = 2'd0;
    localparam t_cfg_idx CFG_SPEED_LIM  = 2'd1;
    localparam t_cfg_idx CFG_POS_TOL    = 2'd2;

    typedef struct packed {
        logic [SQ_W-1:0]   quo_num;  // dividend shifts out, quotient shifts in
        logic [DREM_W-1:0] drem;
        logic [RAD_W-1:0]  rad;      // radicand, two bits consumed per step
        logic [SREM_W-1:0] srem;
        logic [ROOT_W-1:0] root;
        logic [VAL_W-1:0]  speed;
    } t_stage;

    // One restoring divide step, and one square-root digit when do_sqrt is set.
    function automatic t_stage iter_step(t_stage s, logic [VAL_W-1:0] divisor,
                                         logic do_sqrt);
        logic [DREM_W-1:0] dr;
        logic [DREM_W:0]   dsub;
        logic [SREM_W-1:0] sr;
        logic [SREM_W:0]   ssub;
        t_stage            o;
        o    = s;
        dr   = {s.drem[DREM_W-2:0], s.quo_num[SQ_W-1]};
        dsub = {1'b0, dr} - {2'b00, divisor};
        if (!dsub[DREM_W]) begin
            o.drem    = dsub[DREM_W-1:0];
            o.quo_num = {s.quo_num[SQ_W-2:0], 1'b1};
        end else begin
            o.drem    = dr;
            o.quo_num = {s.quo_num[SQ_W-2:0], 1'b0};
        end
        if (do_sqrt) begin
            sr   = {s.srem[SREM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
            ssub = {1'b0, sr} - {2'b00, s.root, 2'b01};
            if (!ssub[SREM_W]) begin
                o.srem = ssub[SREM_W-1:0];
                o.root = {s.root[ROOT_W-2:0], 1'b1};
            end else begin
                o.srem = sr;
                o.root = {s.root[ROOT_W-2:0], 1'b0};
            end
            o.rad = {s.rad[RAD_W-3:0], 2'b00};
        end
        return o;
    endfunction

endpackage

FILE: design/lsps_iter_pipe.sv
// Pipelined divider (speed^2 / accel_step) and integer square root, one bit
// per stage with a shared global advance. Depends on lsps_pkg.
module lsps_iter_pipe
    import lsps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_stage           i_stage,
    input  logic [VAL_W-1:0] i_divisor,
    output logic             o_valid,
    output t_stage           o_stage
);

    logic   r_valid [N_ITER];
    t_stage r_st    [N_ITER];
    t_stage n_st    [N_ITER];

    always_comb begin
        n_st[0] = iter_step(i_stage, i_divisor, 1'b1);
        for (int k = 1; k < N_ITER; k++) begin
            n_st[k] = iter_step(r_st[k-1], i_divisor, logic'(k < N_SQRT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_ITER; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < N_ITER; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_ITER; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_valid[N_ITER-1];
    assign o_stage = r_st[N_ITER-1];

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_valid[N_ITER-1]) && $stable(r_st[N_ITER-1]))
        else $error("iteration pipe moved while stalled");

    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[N_ITER-1] |-> r_st[N_ITER-1].srem <= {r_st[N_ITER-1].root, 1'b0})
        else $error("square-root remainder out of range");

endmodule

FILE: design/linear_speed_profile_step.sv
// Top level of the linear speed profile step: input unpacking, squaring,
// final decision and output register. Depends on lsps_pkg, lsps_iter_pipe.
//
// Use: each transfer on the slave stream carries one control tick (target
// point, current point, current speed); one speed command leaves on the
// master stream per input transfer, in order. The config channel writes
// accel_step (index 0), speed_limit (1) and position_tolerance (2); other
// indices are dropped. It is always ready; write it only while idle.
// Pipeline: an input transfer passes abs/diff, squares, sum, 32 divide stages
// that also carry the 17 square-root steps, decision and output register
// before o_m_tvalid rises. Throughput: one item per cycle while not stalled.
// Reset: all valid bits clear, registers return to 64 / 4096 / 10.
// Stall: while the output holds an untaken result the whole pipeline freezes
// and o_s_tready drops; nothing is lost or repeated.
module linear_speed_profile_step
    import lsps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // target_x, target_y, current_x, current_y, current_speed
    input  logic [5*VAL_W-1:0]   i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // speed_command
    output logic [VAL_W-1:0]     o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    logic [VAL_W-1:0] r_accel_step, r_speed_limit, r_pos_tol;

    logic             w_en;
    logic [VAL_W:0]   w_dx, w_dy, w_ndx, w_ndy;
    logic             r_a_valid, r_b_valid, r_c_valid, r_f_valid, r_m_valid;
    logic [VAL_W-1:0] r_a_adx, r_a_ady, r_a_speed;
    logic [SQ_W-1:0]  r_b_x2, r_b_y2, r_b_s2;
    logic [VAL_W-1:0] r_b_speed;
    t_stage           r_c_stage;
    logic             w_i_valid;
    t_stage           w_i_stage;
    logic             w_far, w_match, n_decel, n_ontgt;
    logic             r_f_decel, r_f_ontgt;
    logic [VAL_W-1:0] r_f_speed;
    logic [VAL_W:0]   w_up;
    logic [VAL_W-1:0] n_cmd, r_m_cmd;

    assign w_en        = !r_m_valid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_step  <= 16'd64;
            r_speed_limit <= 16'd4096;
            r_pos_tol     <= 16'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACCEL_STEP: r_accel_step  <= i_cfg_data;
                CFG_SPEED_LIM:  r_speed_limit <= i_cfg_data;
                CFG_POS_TOL:    r_pos_tol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: coordinate differences and magnitudes
    assign w_dx  = {i_s_tdata[VAL_W-1], i_s_tdata[VAL_W-1:0]}
                 - {i_s_tdata[3*VAL_W-1], i_s_tdata[3*VAL_W-1:2*VAL_W]};
    assign w_dy  = {i_s_tdata[2*VAL_W-1], i_s_tdata[2*VAL_W-1:VAL_W]}
                 - {i_s_tdata[4*VAL_W-1], i_s_tdata[4*VAL_W-1:3*VAL_W]};
    assign w_ndx = '0 - w_dx;
    assign w_ndy = '0 - w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_f_valid <= w_i_valid;
            r_m_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_adx   <= w_dx[VAL_W] ? w_ndx[VAL_W-1:0] : w_dx[VAL_W-1:0];
            r_a_ady   <= w_dy[VAL_W] ? w_ndy[VAL_W-1:0] : w_dy[VAL_W-1:0];
            r_a_speed <= i_s_tdata[5*VAL_W-1:4*VAL_W];
            // stage B: squares
            r_b_x2    <= r_a_adx * r_a_adx;
            r_b_y2    <= r_a_ady * r_a_ady;
            r_b_s2    <= r_a_speed * r_a_speed;
            r_b_speed <= r_a_speed;
            // stage C: radicand and iteration seed
            r_c_stage.quo_num <= r_b_s2;
            r_c_stage.drem    <= '0;
            r_c_stage.rad     <= {1'b0, {1'b0, r_b_x2} + {1'b0, r_b_y2}};
            r_c_stage.srem    <= '0;
            r_c_stage.root    <= '0;
            r_c_stage.speed   <= r_b_speed;
            r_f_decel <= n_decel;
            r_f_ontgt <= n_ontgt;
            r_f_speed <= w_i_stage.speed;
            r_m_cmd   <= n_cmd;
        end
    end

    lsps_iter_pipe u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_c_valid),
        .i_stage   (r_c_stage),
        .i_divisor (r_accel_step),
        .o_valid   (w_i_valid),
        .o_stage   (w_i_stage)
    );

    // stage F: forecast against distance
    assign w_far   = w_i_stage.quo_num > SQ_W'(w_i_stage.root);
    assign w_match = {1'b0, w_i_stage.root}
                   < ({1'b0, w_i_stage.quo_num[ROOT_W-1:0]} + (ROOT_W+1)'(r_pos_tol));
    assign n_decel = w_far || w_match;
    assign n_ontgt = w_i_stage.root < ROOT_W'(r_pos_tol);

    // output stage: command select
    assign w_up = {1'b0, r_f_speed} + {1'b0, r_accel_step};
    always_comb begin
        if (r_f_ontgt) begin
            n_cmd = '0;
        end else if (r_f_decel) begin
            n_cmd = (r_f_speed > r_accel_step) ? r_f_speed - r_accel_step : '0;
        end else begin
            n_cmd = (w_up < {1'b0, r_speed_limit}) ? w_up[VAL_W-1:0] : r_speed_limit;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_cmd;

    a_decel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && r_f_decel && !r_f_ontgt |-> n_cmd <= r_f_speed)
        else $error("deceleration raised the speed");

    a_accel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && !r_f_decel && !r_f_ontgt |-> n_cmd <= r_speed_limit)
        else $error("acceleration passed the speed limit");

endmodule
